// File: rtl/dsce_pkg.sv
// dsce_pkg: shared constants and controller/datapath handshake structs
// for the distinct smaller count engine; depends on nothing
`default_nettype none

package dsce_pkg;

  // default key domain width in bits
  localparam int KEY_BITS_DEF = 16;
  // width of the payload fields on the channels
  localparam int KEY_W        = 16;
  localparam int OUT_W        = 16;
  // width of the per-entry array generation tag
  localparam int EPOCH_BITS   = 8;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // input transfer, start presence/count lookup
    logic query;   // walk the prefix sum positions
    logic setup;   // mark key present, arm the update walk
    logic insert;  // walk the update positions
    logic emit;    // load the result register
    logic clear;   // sweep the memory back to the empty state
  } dsce_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic query_done;
    logic insert_done;
    logic dup;
    logic last;
    logic epoch_full;
    logic clear_done;
  } dsce_sts_t;

endpackage

`default_nettype wire

// File: rtl/dsce_if.sv
// dsce_in_if / dsce_out_if: valid/ready channels for keys and results
// depends on dsce_pkg for field widths
`default_nettype none

interface dsce_in_if;
  logic                       valid;
  logic                       ready;
  logic [dsce_pkg::KEY_W-1:0] key;
  logic                       last_item;

  modport source (output valid, output key, output last_item, input ready);
  modport sink   (input valid, input key, input last_item, output ready);
endinterface

interface dsce_out_if;
  logic                       valid;
  logic                       ready;
  logic [dsce_pkg::OUT_W-1:0] smaller_count;
  logic [dsce_pkg::OUT_W-1:0] running_max;
  logic                       duplicate;

  modport source (output valid, output smaller_count, output running_max,
                  output duplicate, input ready);
  modport sink   (input valid, input smaller_count, input running_max,
                  input duplicate, output ready);
endinterface

`default_nettype wire

// File: rtl/dsce_dp.sv
// dsce_dp: datapath with the presence/Fenwick count memory, walk pointers,
// running maximum and result register; depends on dsce_pkg
`default_nettype none

module dsce_dp #(
  parameter int KEY_BITS = dsce_pkg::KEY_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire dsce_pkg::dsce_cmd_t        cmd,
  output dsce_pkg::dsce_sts_t             sts,
  input  wire logic [dsce_pkg::KEY_W-1:0] key_in,
  input  wire logic                       last_in,
  output logic [dsce_pkg::OUT_W-1:0]      smaller_count,
  output logic [dsce_pkg::OUT_W-1:0]      running_max,
  output logic                            duplicate
);
  import dsce_pkg::*;

  localparam int KB    = KEY_BITS;
  localparam int EB    = EPOCH_BITS;
  localparam int DEPTH = 1 << KB;
  localparam int SW    = (KB > OUT_W) ? KB : OUT_W;

  // one word per key: generation tag, presence of key, count at position key
  typedef struct packed {
    logic [EB-1:0] epoch;
    logic          present;
    logic [KB-1:0] cnt;
  } word_t;

  word_t mem [0:DEPTH-1];

  word_t         rd_word;
  logic          mem_re;
  logic [KB-1:0] mem_ra;
  logic          mem_we;
  logic [KB-1:0] mem_wa;
  word_t         mem_wd;

  logic [KB-1:0]    key_r;
  logic             last_r;
  logic [KB:0]      ptr;
  logic [KB-1:0]    ins_addr;
  logic             pend;
  logic             first;
  logic [KB-1:0]    sum;
  logic             present_r;
  logic [KB-1:0]    base_cnt;
  logic [EB-1:0]    epoch;
  logic [OUT_W-1:0] best;
  logic [KB-1:0]    clr_ptr;

  logic [KB-1:0]    key_k;
  logic [KB-1:0]    ptr_lo;
  logic [KB:0]      lowbit;
  logic             rd_ok;
  logic [KB-1:0]    rd_cnt;
  logic             rd_pres;
  logic [SW-1:0]    sum_w;
  logic [OUT_W-1:0] cnt_sat;
  logic [OUT_W-1:0] new_max;

  assign key_k   = KB'(key_in);
  assign ptr_lo  = ptr[KB-1:0];
  assign lowbit  = ptr & (~ptr + (KB+1)'(1));

  // entries tagged with an older generation read as empty
  assign rd_ok   = (rd_word.epoch == epoch);
  assign rd_cnt  = rd_ok ? rd_word.cnt : '0;
  assign rd_pres = rd_ok & rd_word.present;

  // saturate the count to the output width
  assign sum_w   = SW'(sum);
  assign cnt_sat = (sum_w > SW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : sum_w[OUT_W-1:0];
  assign new_max = (cnt_sat > best) ? cnt_sat : best;

  // status back to the controller
  assign sts.query_done  = !pend && (ptr_lo == '0);
  assign sts.insert_done = !pend && ptr[KB];
  assign sts.dup         = present_r;
  assign sts.last        = last_r;
  assign sts.epoch_full  = &epoch;
  assign sts.clear_done  = &clr_ptr;

  // memory read port select
  always_comb begin
    mem_re = 1'b0;
    mem_ra = ptr_lo;
    if (cmd.load) begin
      mem_re = 1'b1;
      mem_ra = key_k;
    end else if (cmd.query && (ptr_lo != '0)) begin
      mem_re = 1'b1;
    end else if (cmd.insert && !ptr[KB]) begin
      mem_re = 1'b1;
    end
  end

  // memory write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ins_addr;
    mem_wd = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
      mem_wa = clr_ptr;
    end else if (cmd.setup) begin
      mem_we         = 1'b1;
      mem_wa         = key_r;
      mem_wd.epoch   = epoch;
      mem_wd.present = 1'b1;
      mem_wd.cnt     = base_cnt;
    end else if (cmd.insert && pend) begin
      mem_we         = 1'b1;
      mem_wd.epoch   = epoch;
      mem_wd.present = rd_pres;
      mem_wd.cnt     = rd_cnt + KB'(1);
    end
  end

  // memory array, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_word <= mem[mem_ra];
    end
  end

  // walk pointers and accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r  <= key_k;
      last_r <= last_in;
      ptr    <= {1'b0, key_k & (key_k - KB'(1))};
      first  <= 1'b1;
      sum    <= '0;
    end else if (cmd.query) begin
      if (pend) begin
        // position zero holds nothing: key zero adds no count
        if (!(first && (key_r == '0))) begin
          sum <= sum + rd_cnt;
        end
        if (first) begin
          present_r <= rd_pres;
          base_cnt  <= rd_cnt;
          first     <= 1'b0;
        end
      end
      if (ptr_lo != '0) begin
        ptr <= {1'b0, ptr_lo & (ptr_lo - KB'(1))};
      end
    end else if (cmd.setup) begin
      ptr <= {1'b0, key_r} + (KB+1)'(1);
    end else if (cmd.insert) begin
      if (!ptr[KB]) begin
        ins_addr <= ptr_lo;
        ptr      <= ptr + lowbit;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      smaller_count <= cnt_sat;
      running_max   <= new_max;
      duplicate     <= present_r;
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      epoch   <= '0;
      best    <= '0;
      clr_ptr <= '0;
    end else begin
      if (cmd.load) begin
        pend <= 1'b1;
      end else if (cmd.query) begin
        pend <= (ptr_lo != '0);
      end else if (cmd.setup) begin
        pend <= 1'b0;
      end else if (cmd.insert) begin
        pend <= !ptr[KB];
      end
      if (cmd.emit) begin
        best <= last_r ? '0 : new_max;
        if (last_r && !(&epoch)) begin
          epoch <= epoch + EB'(1);
        end
      end
      if (cmd.clear) begin
        clr_ptr <= clr_ptr + KB'(1);
        if (&clr_ptr) begin
          epoch <= EB'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/dsce_ctrl.sv
// dsce_ctrl: sequencer for lookup, update walk, result transfer and memory
// sweep; depends on dsce_pkg
`default_nettype none

module dsce_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dsce_pkg::dsce_cmd_t      cmd,
  input  wire dsce_pkg::dsce_sts_t sts
);
  import dsce_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUERY,
    S_SETUP,
    S_INSERT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_QUERY;
      end
      S_QUERY: begin
        cmd.query = 1'b1;
        if (sts.query_done) state_next = sts.dup ? S_FINISH : S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        if (sts.insert_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.emit = slot_free;
        if (slot_free) begin
          state_next = (sts.last && sts.epoch_full) ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/distinct_smaller_count_engine_top.sv
// Distinct smaller count engine, top level.
// Keys of an array arrive on the keys channel from the last element to the
// first; last_item marks the final key of an array. For each key one result
// transfer on the results channel gives smaller_count (distinct keys stored
// so far in this array that are strictly smaller), running_max (largest
// smaller_count so far in this array) and duplicate (key already stored).
// Keys are kept as presence bits plus Fenwick counts in one memory of
// 2^KEY_BITS words, each tagged with an array generation number.
// Each key passes through a transfer, a prefix walk over the Fenwick
// positions and, for a new key only, a setup step and an update walk,
// then the result is loaded. Keys are handled one at a time, set by the
// single read and write port of the count memory.
// The next key is taken as soon as a result is loaded, while that result
// may still wait; a stalled receiver holds the engine in its finish state
// once a second result is ready.
// Reset starts a sweep over all 2^KEY_BITS words that empties the memory;
// keys are refused until it ends. The same sweep runs after every 255th
// array, when the generation tag runs out.
`default_nettype none

module distinct_smaller_count_engine_top #(
  parameter int KEY_BITS = dsce_pkg::KEY_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  dsce_in_if.sink  keys,
  dsce_out_if.source results
);
  import dsce_pkg::*;

  dsce_cmd_t cmd;
  dsce_sts_t sts;

  // sequencer
  dsce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (keys.valid),
    .in_ready  (keys.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // count memory and result datapath
  dsce_dp #(
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .key_in        (keys.key),
    .last_in       (keys.last_item),
    .smaller_count (results.smaller_count),
    .running_max   (results.running_max),
    .duplicate     (results.duplicate)
  );

endmodule

`default_nettype wire

// File: rtl/dsce_checker.sv
// dsce_checker: port-level assertions for the distinct smaller count engine
// and the bind that attaches them to the top level; depends on dsce_pkg
`default_nettype none

module dsce_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [dsce_pkg::OUT_W-1:0] smaller_count,
  input wire logic [dsce_pkg::OUT_W-1:0] running_max,
  input wire logic                       duplicate
);
  import dsce_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      $stable(smaller_count) && $stable(running_max) && $stable(duplicate))
    else $error("result payload changed while stalled");

  // the running maximum covers the count it is reported with
  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running_max >= smaller_count)
    else $error("running_max below smaller_count");

  // one key at a time: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("key taken while previous key still in work");

endmodule

bind distinct_smaller_count_engine_top dsce_checker u_dsce_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (keys.valid),
  .in_ready      (keys.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .smaller_count (results.smaller_count),
  .running_max   (results.running_max),
  .duplicate     (results.duplicate)
);

`default_nettype wire
